// ===== hw/rtl/rmv_pkg.sv =====
// Shared types for the running mean / variance / min / max block.
// Used by rmv_front, rmv_div, rmv_back and the top level.
`default_nettype none
package rmv_pkg;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_MERGE = 1'b1;

	typedef struct packed {
		logic              k_zero;
		logic signed [31:0] omean;
		logic [31:0]       k;
		logic [63:0]       ospread;
		logic signed [31:0] olow;
		logic signed [31:0] ohigh;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [32:0] hi;
		logic [63:0] lo;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL_STEP,
		ST_DIV_STEP,
		ST_WAIT_STEP,
		ST_MUL_SQ,
		ST_MUL_NK,
		ST_MUL_WIDE,
		ST_DIV_TERM,
		ST_WAIT_TERM,
		ST_UPDATE,
		ST_DIV_VAR,
		ST_WAIT_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned IN_DATA_BITS = 192;
	localparam int unsigned OUT_DATA_BITS = 232;

endpackage
`default_nettype wire

// ===== hw/rtl/rmv_front.sv =====
// Front end: accepts input transactions, classifies the action and queues the item.
// Depends on rmv_pkg.
`default_nettype none
module rmv_front #(
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [31:0]           value,
	input  wire logic [31:0]           item_count,
	input  wire logic [63:0]           other_spread,
	input  wire logic [31:0]           other_low,
	input  wire logic [31:0]           other_high,
	output logic                       q_valid,
	output rmv_pkg::item_t             q_item,
	input  wire logic                  pop
);

	rmv_pkg::item_t item_q [rmv_pkg::QUEUE_DEPTH];
	rmv_pkg::item_t cls;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic signed [31:0] x;
	logic           push;

	always_comb begin
		x = 32'($signed(value[SAMPLE_BITS-1:0]));
		cls.k_zero = (item_count == '0);
		cls.omean = x;
		cls.k = item_count;
		if (action == rmv_pkg::ACT_MERGE) begin
			cls.ospread = other_spread;
			cls.olow = 32'($signed(other_low[SAMPLE_BITS-1:0]));
			cls.ohigh = 32'($signed(other_high[SAMPLE_BITS-1:0]));
		end else begin
			cls.ospread = '0;
			cls.olow = x;
			cls.ohigh = x;
		end
	end

	assign in_ready = (fill_q != 2'(rmv_pkg::QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (fill_q != '0);
	assign q_item = item_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rmv_div.sv =====
// Radix-2 restoring divider: 64 quotient bits of (hi:lo)/den, one bit per cycle.
// Depends on rmv_pkg; hi must be below den.
`default_nettype none
module rmv_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  rmv_pkg::div_req_t req,
	output rmv_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [63:0] sh_q;
	logic [32:0] den_q;
	logic [33:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, sh_q[63]};
	assign ge = (rem_sh >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quo = sh_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.hi;
			sh_q <= req.lo;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
			sh_q <= {sh_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rmv_back.sv =====
// Back end: sequencer for the merge update, variance and square root, plus result register.
// Depends on rmv_pkg; drives the shared rmv_div.
`default_nettype none
module rmv_back #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  rmv_pkg::item_t    q_item,
	output logic              pop,
	output rmv_pkg::div_req_t div_req,
	input  rmv_pkg::div_rsp_t div_rsp,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [31:0]       sample_count,
	output logic [31:0]       mean_value,
	output logic [63:0]       variance_value,
	output logic [31:0]       deviation,
	output logic [31:0]       lowest,
	output logic [31:0]       highest,
	output logic              overflow
);

	localparam logic [32:0] CMAX = 33'({COUNT_BITS{1'b1}});

	rmv_pkg::state_t state_q, state_d;
	rmv_pkg::item_t  w_q;

	logic [COUNT_BITS-1:0] count_q;
	logic signed [31:0]    mean_q;
	logic [63:0]           spread_q;
	logic signed [31:0]    low_q;
	logic signed [31:0]    high_q;
	logic                  ovf_q;

	logic        neg_q;
	logic [31:0] ad_q;
	logic [32:0] total_q;
	logic [63:0] prod_q;
	logic [63:0] sq_q;
	logic [63:0] nk_q;
	logic [63:0] pp_q;
	logic [1:0]  pp_sh_q;
	logic [2:0]  pcnt_q;
	logic [127:0] wide_q;
	logic [63:0] term_q;
	logic [63:0] var_q;
	logic [63:0] sv_q;
	logic [31:0] root_q;
	logic [33:0] srem_q;
	logic [4:0]  scnt_q;

	logic [32:0] d;
	logic [31:0] ma, mb;
	logic [32:0] m33;
	logic [64:0] s1, s2;
	logic [63:0] s1c;
	logic [35:0] rem_sh, trial;
	logic        sge;
	logic        load;
	logic        term_ovf;

	always_comb begin
		d = 33'(w_q.omean) - 33'(mean_q);
		ma = pcnt_q[1] ? sq_q[63:32] : sq_q[31:0];
		mb = pcnt_q[0] ? nk_q[63:32] : nk_q[31:0];
		m33 = neg_q ? (33'(mean_q) - {1'b0, div_rsp.quo[31:0]})
			: (33'(mean_q) + {1'b0, div_rsp.quo[31:0]});
		s1 = {1'b0, spread_q} + {1'b0, w_q.ospread};
		s1c = s1[64] ? '1 : s1[63:0];
		s2 = {1'b0, s1c} + {1'b0, term_q};
		rem_sh = {srem_q, sv_q[63:62]};
		trial = {2'b00, root_q, 2'b01};
		sge = (rem_sh >= trial);
		term_ovf = (wide_q[127:64] >= 64'(total_q));
		load = (!out_valid || out_ready);
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		div_req = '0;
		unique case (state_q)
			rmv_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					state_d = q_item.k_zero ? rmv_pkg::ST_DIV_VAR : rmv_pkg::ST_DIFF;
				end
			end
			rmv_pkg::ST_DIFF: state_d = rmv_pkg::ST_MUL_STEP;
			rmv_pkg::ST_MUL_STEP: state_d = rmv_pkg::ST_DIV_STEP;
			rmv_pkg::ST_DIV_STEP: begin
				div_req.start = 1'b1;
				div_req.lo = prod_q;
				div_req.den = total_q;
				state_d = rmv_pkg::ST_WAIT_STEP;
			end
			rmv_pkg::ST_WAIT_STEP: begin
				if (div_rsp.done) begin
					state_d = rmv_pkg::ST_MUL_SQ;
				end
			end
			rmv_pkg::ST_MUL_SQ: state_d = rmv_pkg::ST_MUL_NK;
			rmv_pkg::ST_MUL_NK: state_d = rmv_pkg::ST_MUL_WIDE;
			rmv_pkg::ST_MUL_WIDE: begin
				if (pcnt_q == 3'd4) begin
					state_d = rmv_pkg::ST_DIV_TERM;
				end
			end
			rmv_pkg::ST_DIV_TERM: begin
				if (term_ovf) begin
					state_d = rmv_pkg::ST_UPDATE;
				end else begin
					div_req.start = 1'b1;
					div_req.hi = wide_q[96:64];
					div_req.lo = wide_q[63:0];
					div_req.den = total_q;
					state_d = rmv_pkg::ST_WAIT_TERM;
				end
			end
			rmv_pkg::ST_WAIT_TERM: begin
				if (div_rsp.done) begin
					state_d = rmv_pkg::ST_UPDATE;
				end
			end
			rmv_pkg::ST_UPDATE: state_d = rmv_pkg::ST_DIV_VAR;
			rmv_pkg::ST_DIV_VAR: begin
				if ((count_q >> 1) != '0) begin
					div_req.start = 1'b1;
					div_req.lo = spread_q;
					div_req.den = 33'(count_q) - 33'd1;
					state_d = rmv_pkg::ST_WAIT_VAR;
				end else begin
					state_d = rmv_pkg::ST_SQRT;
				end
			end
			rmv_pkg::ST_WAIT_VAR: begin
				if (div_rsp.done) begin
					state_d = rmv_pkg::ST_SQRT;
				end
			end
			rmv_pkg::ST_SQRT: begin
				if (scnt_q == '1) begin
					state_d = rmv_pkg::ST_DONE;
				end
			end
			rmv_pkg::ST_DONE: begin
				if (load) begin
					state_d = rmv_pkg::ST_IDLE;
				end
			end
			default: state_d = rmv_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rmv_pkg::ST_IDLE: w_q <= q_item;
			rmv_pkg::ST_DIFF: begin
				neg_q <= d[32];
				ad_q <= d[32] ? 32'(-d) : d[31:0];
				total_q <= 33'(count_q) + 33'(w_q.k);
			end
			rmv_pkg::ST_MUL_STEP: prod_q <= 64'(ad_q) * 64'(w_q.k);
			rmv_pkg::ST_MUL_SQ: sq_q <= 64'(ad_q) * 64'(ad_q);
			rmv_pkg::ST_MUL_NK: begin
				nk_q <= 64'(32'(count_q)) * 64'(w_q.k);
				pcnt_q <= '0;
				wide_q <= '0;
			end
			rmv_pkg::ST_MUL_WIDE: begin
				if (pcnt_q != 3'd0) begin
					wide_q <= wide_q + (128'(pp_q) << (7'd32 * 7'(pp_sh_q)));
				end
				pp_q <= 64'(ma) * 64'(mb);
				pp_sh_q <= 2'(pcnt_q[1]) + 2'(pcnt_q[0]);
				pcnt_q <= pcnt_q + 3'd1;
			end
			rmv_pkg::ST_DIV_TERM: term_q <= '1;
			rmv_pkg::ST_WAIT_TERM: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quo;
				end
			end
			rmv_pkg::ST_DIV_VAR: begin
				var_q <= '0;
				sv_q <= '0;
				root_q <= '0;
				srem_q <= '0;
			end
			rmv_pkg::ST_WAIT_VAR: begin
				var_q <= div_rsp.quo;
				sv_q <= div_rsp.quo;
			end
			rmv_pkg::ST_SQRT: begin
				srem_q <= sge ? 34'(rem_sh - trial) : rem_sh[33:0];
				root_q <= {root_q[30:0], sge};
				sv_q <= {sv_q[61:0], 2'b00};
			end
			default: begin
			end
		endcase
		if (state_q == rmv_pkg::ST_DONE && load) begin
			sample_count <= 32'(count_q);
			mean_value <= mean_q;
			variance_value <= var_q;
			deviation <= root_q;
			lowest <= low_q;
			highest <= high_q;
			overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmv_pkg::ST_IDLE;
			count_q <= '0;
			mean_q <= '0;
			spread_q <= '0;
			low_q <= 32'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
			high_q <= 32'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}));
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
			scnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rmv_pkg::ST_WAIT_STEP && div_rsp.done) begin
				mean_q <= m33[31:0];
			end
			if (state_q == rmv_pkg::ST_DIV_TERM && term_ovf) begin
				ovf_q <= 1'b1;
			end
			if (state_q == rmv_pkg::ST_UPDATE) begin
				spread_q <= s2[64] ? '1 : s2[63:0];
				if (s1[64] || s2[64] || (total_q > CMAX)) begin
					ovf_q <= 1'b1;
				end
				if (w_q.olow < low_q) begin
					low_q <= w_q.olow;
				end
				if (w_q.ohigh > high_q) begin
					high_q <= w_q.ohigh;
				end
				count_q <= (total_q > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(total_q);
			end
			if (state_q == rmv_pkg::ST_SQRT) begin
				scnt_q <= scnt_q + 5'd1;
			end else begin
				scnt_q <= '0;
			end
			if (state_q == rmv_pkg::ST_DONE && load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/running_mean_variance_min_max.sv =====
// Top level of the running mean / variance / min / max block.
// Depends on rmv_pkg, rmv_front, rmv_div and rmv_back.
//
// channel  dir  tdata (low bit up)                                        tuser
// s_       in   value, item_count, other_spread, other_low, other_high   action
// m_       out  sample_count, mean_value, variance_value, deviation,     -
//               lowest, highest, overflow, 7 zero bits
//
// An item with a nonzero count makes up to three 64-bit divisions in the one serial
// divider, then 32 square-root steps; an item with a zero count goes straight to the
// variance division. The two-entry queue takes new items while the back end works.
// Reset is asynchronous and leaves the statistics empty; results wait in the output
// register under back-pressure.
`default_nettype none
module running_mean_variance_min_max #(
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// value, item_count, other_spread, other_low, other_high
	input  wire logic [rmv_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// action
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// sample_count, mean_value, variance_value, deviation, lowest, highest, overflow
	output logic [rmv_pkg::OUT_DATA_BITS-1:0]       m_tdata
);

	logic              q_valid;
	logic              pop;
	rmv_pkg::item_t    q_item;
	rmv_pkg::div_req_t div_req;
	rmv_pkg::div_rsp_t div_rsp;
	logic [31:0] sample_count, mean_value, deviation, lowest, highest;
	logic [63:0] variance_value;
	logic        overflow;

	rmv_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.action(s_tuser),
		.value(s_tdata[31:0]), .item_count(s_tdata[63:32]),
		.other_spread(s_tdata[127:64]), .other_low(s_tdata[159:128]),
		.other_high(s_tdata[191:160]),
		.q_valid(q_valid), .q_item(q_item), .pop(pop)
	);

	rmv_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	rmv_back #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .pop(pop),
		.div_req(div_req), .div_rsp(div_rsp),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sample_count(sample_count), .mean_value(mean_value),
		.variance_value(variance_value), .deviation(deviation),
		.lowest(lowest), .highest(highest), .overflow(overflow)
	);

	assign m_tdata = {7'b0, overflow, highest, lowest, deviation, variance_value,
		mean_value, sample_count};

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_valid) else $error("input stalled with empty queue");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |=> !div_rsp.done) else $error("divider done held");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_req.start) else $error("divider restarted");

endmodule
`default_nettype wire
